FILE: src/cfe_pkg.sv
// Shared types and constants of the condition flag evaluator.
// Holds the mode codes, flag bit positions and the beat payload structs.
// No dependencies.
`timescale 1ns / 1ps

package cfe_pkg;

   typedef enum logic [3:0] {
      MODE_GENERAL = 4'd0,
      MODE_ALU4    = 4'd1,
      MODE_MCP     = 4'd2,
      MODE_MULS    = 4'd3,
      MODE_MULU    = 4'd4,
      MODE_MOVE4   = 4'd5,
      MODE_MOVE2   = 4'd6,
      MODE_SETF    = 4'd7,
      MODE_CLRF    = 4'd8,
      MODE_WRITE   = 4'd9,
      MODE_READ    = 4'd10,
      MODE_LSHIFT  = 4'd11,
      MODE_RSHIFT  = 4'd12
   } mode_type;

   localparam int CcsWidth  = 32;
   localparam int FlagWidth = 9;   // flags C..R, bits 0..8

   localparam int FlagCBit = 0;
   localparam int FlagVBit = 1;
   localparam int FlagZBit = 2;
   localparam int FlagNBit = 3;
   localparam int FlagXBit = 4;
   localparam int FlagRBit = 8;

   localparam logic [CcsWidth-1:0] KeepTopMask = 32'hC000_0000;

   typedef struct packed {
      logic [3:0]          mode;
      logic [31:0]         src_value;
      logic [31:0]         dst_value;
      logic [31:0]         result_value;
      logic [2:0]          operand_size;
      logic                is_sub_or_cmp;
      logic                is_add_with_carry;
      logic [31:0]         flag_mask;
      logic                x_override_valid;
      logic                x_override_value;
      logic [31:0]         write_value;
   } req_payload_type;

   typedef struct packed {
      logic [CcsWidth-1:0] ccs_out;
   } rsp_payload_type;

endpackage

FILE: src/cfe_if.sv
// Valid/ready channel interfaces for the condition flag evaluator.
// Depends on cfe_pkg for the payload structs.
`timescale 1ns / 1ps

interface cfe_req_if;
   import cfe_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cfe_rsp_if;
   import cfe_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/condition_flag_evaluator.sv
// Condition flag evaluator: condition code register with per-instruction update.
// Depends on cfe_pkg and the channel interfaces in cfe_if.sv.
//
//   channel  | dir | beat carries
//   req_bus  | in  | mode, operands, size, sub/addc, mask, X override, write bits
//   rsp_bus  | out | ccs_out, the register after the beat's update
//
// Two registers: input register, then flag logic and writeback in one pass
// into the response register. An accepted beat waits in the input register
// until the response register is free; one beat is taken per cycle unless stalled.
// The register is updated as a beat moves into the response register, so
// each beat sees the result of the one before it.
// Synchronous reset clears the register and both valids.
// A stall on rsp_bus holds the response, then the input register; req_bus
// drops ready only while both are full and rsp_bus is stalled.
`timescale 1ns / 1ps

module condition_flag_evaluator (
   input  logic        clock,
   input  logic        reset,
   cfe_req_if.sink     req_bus,
   cfe_rsp_if.source   rsp_bus
);
   import cfe_pkg::*;

   // N/Z/V and C (or R) from the sign bits of the operand width
   function automatic logic [FlagWidth-1:0] sign_rule(
      input logic ss, input logic ds, input logic rs, input logic rz, input logic use_r);
      logic [FlagWidth-1:0] f;
      logic [FlagWidth-1:0] cbit;
      f    = '0;
      cbit = '0;
      if (use_r) begin
         cbit[FlagRBit] = 1'b1;
      end else begin
         cbit[FlagCBit] = 1'b1;
      end
      if (rs) begin
         f[FlagNBit] = 1'b1;
         if (!ss && !ds) begin
            f[FlagVBit] = 1'b1;
         end else if (ss && ds) begin
            f = f | cbit;
         end
      end else begin
         f[FlagZBit] = rz;
         f[FlagVBit] = ss && ds;
         if (ss || ds) begin
            f = f | cbit;
         end
      end
      return f;
   endfunction

   // ---------------- input register ----------------
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff;
   logic            s1_ready, s1_fire;

   // ---------------- response register ----------------
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CcsWidth-1:0] rsp_ccs_ff;
   logic                rsp_slot_free;

   logic [CcsWidth-1:0] ccs_ff, ccs_in;

   logic                 req_fire;
   logic signed [32:0]   mul_a, mul_b;
   logic signed [63:0]   product;
   logic [FlagWidth-1:0] flags;
   logic                 is_eval;
   logic                 x_now;
   logic [CcsWidth-1:0]  mask_eff;
   logic [CcsWidth-1:0]  flags_wide;

   assign rsp_slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign s1_ready      = !s1_valid_ff || rsp_slot_free;
   assign s1_fire       = s1_valid_ff && rsp_slot_free;
   assign req_fire      = req_bus.valid && s1_ready;

   assign req_bus.ready        = s1_ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.data.ccs_out = rsp_ccs_ff;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !rsp_slot_free);
   assign rsp_valid_in = s1_fire  || (rsp_valid_ff && !rsp_bus.ready);

   // Product: sign-extend for muls, zero-extend for mulu
   always_comb begin
      if (s1_data_ff.mode == MODE_MULS) begin
         mul_a = {s1_data_ff.src_value[31], s1_data_ff.src_value};
         mul_b = {s1_data_ff.dst_value[31], s1_data_ff.dst_value};
      end else begin
         mul_a = {1'b0, s1_data_ff.src_value};
         mul_b = {1'b0, s1_data_ff.dst_value};
      end
      product = mul_a * mul_b;
   end

   // Flag computation, state independent
   always_comb begin
      flags = '0;
      unique case (s1_data_ff.mode)
         MODE_GENERAL: begin
            if (s1_data_ff.operand_size == 3'd1) begin
               flags = sign_rule(s1_data_ff.src_value[7], s1_data_ff.dst_value[7],
                  s1_data_ff.result_value[7], s1_data_ff.result_value[7:0] == 8'h0, 1'b0);
            end else if (s1_data_ff.operand_size == 3'd2) begin
               flags = sign_rule(s1_data_ff.src_value[15], s1_data_ff.dst_value[15],
                  s1_data_ff.result_value[15], s1_data_ff.result_value[15:0] == 16'h0,
                  1'b0);
            end else if (s1_data_ff.operand_size == 3'd4) begin
               flags = sign_rule(s1_data_ff.src_value[31], s1_data_ff.dst_value[31],
                  s1_data_ff.result_value[31], s1_data_ff.result_value == 32'h0, 1'b0);
            end
            flags[FlagCBit] = flags[FlagCBit] ^ s1_data_ff.is_sub_or_cmp;
         end
         MODE_ALU4: begin
            flags = sign_rule(s1_data_ff.src_value[31], s1_data_ff.dst_value[31],
               s1_data_ff.result_value[31], s1_data_ff.result_value == 32'h0, 1'b0);
            flags[FlagCBit] = flags[FlagCBit] ^ s1_data_ff.is_sub_or_cmp;
         end
         MODE_MCP: begin
            flags = sign_rule(s1_data_ff.src_value[31], s1_data_ff.dst_value[31],
               s1_data_ff.result_value[31], s1_data_ff.result_value == 32'h0, 1'b1);
         end
         MODE_MULS, MODE_MULU: begin
            if (product == 64'h0) begin
               flags[FlagZBit] = 1'b1;
            end else begin
               flags[FlagNBit] = product[63];
            end
            if (s1_data_ff.mode == MODE_MULS) begin
               flags[FlagVBit] = product[63:32] != {32{s1_data_ff.result_value[31]}};
            end else begin
               flags[FlagVBit] = product[63:32] != 32'h0;
            end
         end
         MODE_MOVE4: begin
            if (s1_data_ff.result_value[31]) begin
               flags[FlagNBit] = 1'b1;
            end else begin
               flags[FlagZBit] = s1_data_ff.result_value == 32'h0;
            end
         end
         MODE_MOVE2: begin
            if (s1_data_ff.result_value[15]) begin
               flags[FlagNBit] = 1'b1;
            end else begin
               flags[FlagZBit] = s1_data_ff.result_value[15:0] == 16'h0;
            end
         end
         default: begin
            flags = '0;
         end
      endcase
   end

   // Register update from the beat in the input register
   always_comb begin
      is_eval    = s1_data_ff.mode <= MODE_MOVE2;
      x_now      = s1_data_ff.x_override_valid ? s1_data_ff.x_override_value
                                               : ccs_ff[FlagXBit];
      mask_eff   = s1_data_ff.flag_mask;
      // keep Z while extending or adding with carry
      if ((x_now || s1_data_ff.is_add_with_carry) && flags[FlagZBit]) begin
         mask_eff[FlagZBit] = 1'b0;
      end
      flags_wide = {{(CcsWidth-FlagWidth){1'b0}}, flags};
      ccs_in     = ccs_ff;
      if (is_eval) begin
         ccs_in           = (ccs_ff & ~mask_eff) | (flags_wide & mask_eff);
         // drop X on every evaluation
         ccs_in[FlagXBit] = 1'b0;
      end else begin
         unique case (s1_data_ff.mode)
            MODE_SETF:   ccs_in = ccs_ff | s1_data_ff.write_value;
            MODE_CLRF:   ccs_in = ccs_ff & ~s1_data_ff.write_value;
            MODE_WRITE:  ccs_in = s1_data_ff.write_value;
            MODE_LSHIFT: ccs_in = {ccs_ff[31:30], ccs_ff[19:0], 10'b0};
            MODE_RSHIFT: ccs_in = {ccs_ff[31:30], 8'b0, ccs_ff[31:10]};
            default:     ccs_in = ccs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ccs_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            ccs_ff <= ccs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_bus.data;
      end
      if (s1_fire) begin
         rsp_ccs_ff <= ccs_in;
      end
   end

   // The register moves only when a beat leaves the input register
   a_ccs_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(ccs_ff))
      else $error("ccs changed without a beat");

   // The response always shows the register as just updated
   a_rsp_matches: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (rsp_bus.data.ccs_out == ccs_ff) && rsp_bus.valid)
      else $error("response does not match ccs");

   // Evaluation modes always clear X
   a_x_cleared: assert property (@(posedge clock) disable iff (reset)
      s1_fire && (s1_data_ff.mode <= MODE_MOVE2) |=> !ccs_ff[FlagXBit])
      else $error("X survived a flag evaluation");

   // Shifts keep the top two bits
   a_shift_top: assert property (@(posedge clock) disable iff (reset)
      s1_fire && ((s1_data_ff.mode == MODE_LSHIFT) || (s1_data_ff.mode == MODE_RSHIFT))
      |=> ccs_ff[31:30] == $past(ccs_ff[31:30]))
      else $error("shift disturbed top bits");

   // A stalled input register keeps its beat
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_slot_free |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("input beat lost under stall");

   // A stalled response keeps its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.data))
      else $error("response beat lost under stall");

endmodule

FILE: tb/sv/ccs_update_checker.sv
// Checker for the condition flag evaluator: tracks the condition code register
// per accepted request beat and compares every response beat against it.
// Depends on cfe_pkg and the channel interfaces in cfe_if.sv.
`timescale 1ns / 1ps

module ccs_update_checker
   import cfe_pkg::*;
(
   input  logic clock,
   input  logic reset,
   cfe_req_if   req_mon,
   cfe_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_beats
);

   localparam logic [31:0] FlagC = 32'd1 << FlagCBit;
   localparam logic [31:0] FlagV = 32'd1 << FlagVBit;
   localparam logic [31:0] FlagZ = 32'd1 << FlagZBit;
   localparam logic [31:0] FlagN = 32'd1 << FlagNBit;
   localparam logic [31:0] FlagX = 32'd1 << FlagXBit;
   localparam logic [31:0] FlagR = 32'd1 << FlagRBit;

   logic [31:0] ccs_model;
   logic [31:0] expected_ccs[$];
   int          failures;

   // N/Z/V and carry (or R) from the sign bits at the operand width
   function automatic logic [31:0] sign_rule_flags(input logic [31:0] src, dst, res,
                                                   input logic [31:0] sign_bit, width_mask,
                                                   input logic [31:0] carry_flag);
      logic        src_neg;
      logic        dst_neg;
      logic [31:0] flags;
      src_neg = |(src & sign_bit);
      dst_neg = |(dst & sign_bit);
      flags = '0;
      if (|(res & sign_bit)) begin
         flags |= FlagN;
         if (!src_neg && !dst_neg) flags |= FlagV;
         else if (src_neg && dst_neg) flags |= carry_flag;
      end else begin
         if ((res & width_mask) == '0) flags |= FlagZ;
         if (src_neg && dst_neg) flags |= FlagV;
         if (src_neg || dst_neg) flags |= carry_flag;
      end
      return flags;
   endfunction

   function automatic logic [31:0] next_ccs(input logic [31:0] ccs, input req_payload_type beat);
      logic [31:0]        flags;
      logic [31:0]        mask;
      logic [31:0]        shifted;
      logic [31:0]        product_high;
      logic signed [63:0] signed_product;
      logic [63:0]        unsigned_product;
      logic               evaluated;
      logic               x_now;
      flags = '0;
      evaluated = 1'b1;
      case (beat.mode)
         MODE_GENERAL: begin
            case (beat.operand_size)
               3'd1: flags = sign_rule_flags(beat.src_value, beat.dst_value, beat.result_value,
                                             32'h0000_0080, 32'h0000_00FF, FlagC);
               3'd2: flags = sign_rule_flags(beat.src_value, beat.dst_value, beat.result_value,
                                             32'h0000_8000, 32'h0000_FFFF, FlagC);
               3'd4: flags = sign_rule_flags(beat.src_value, beat.dst_value, beat.result_value,
                                             32'h8000_0000, 32'hFFFF_FFFF, FlagC);
               default: flags = '0;
            endcase
            // borrow is the inverted carry, even when no size matched
            if (beat.is_sub_or_cmp) flags ^= FlagC;
         end
         MODE_ALU4: begin
            flags = sign_rule_flags(beat.src_value, beat.dst_value, beat.result_value,
                                    32'h8000_0000, 32'hFFFF_FFFF, FlagC);
            if (beat.is_sub_or_cmp) flags ^= FlagC;
         end
         MODE_MCP: begin
            flags = sign_rule_flags(beat.src_value, beat.dst_value, beat.result_value,
                                    32'h8000_0000, 32'hFFFF_FFFF, FlagR);
         end
         MODE_MULS: begin
            signed_product = $signed({{32{beat.src_value[31]}}, beat.src_value}) *
                             $signed({{32{beat.dst_value[31]}}, beat.dst_value});
            product_high = signed_product[63:32];
            if (signed_product == 0) flags |= FlagZ;
            else if (signed_product < 0) flags |= FlagN;
            if (beat.result_value[31] ? (product_high != 32'hFFFF_FFFF) : (product_high != '0))
               flags |= FlagV;
         end
         MODE_MULU: begin
            unsigned_product = {32'd0, beat.src_value} * {32'd0, beat.dst_value};
            if (unsigned_product == '0) flags |= FlagZ;
            else if (unsigned_product[63]) flags |= FlagN;
            if (unsigned_product[63:32] != '0) flags |= FlagV;
         end
         MODE_MOVE4: begin
            if (beat.result_value[31]) flags |= FlagN;
            else if (beat.result_value == '0) flags |= FlagZ;
         end
         MODE_MOVE2: begin
            if (beat.result_value[15]) flags |= FlagN;
            else if (beat.result_value[15:0] == '0) flags |= FlagZ;
         end
         default: evaluated = 1'b0;
      endcase

      if (evaluated) begin
         x_now = beat.x_override_valid ? beat.x_override_value : ccs[FlagXBit];
         mask = beat.flag_mask;
         // hold Z across extended or add-with-carry chains
         if ((x_now || beat.is_add_with_carry) && (flags & FlagZ) != '0) mask &= ~FlagZ;
         return (ccs & ~(mask | FlagX)) | (flags & mask);
      end

      case (beat.mode)
         MODE_SETF:   return ccs | beat.write_value;
         MODE_CLRF:   return ccs & ~beat.write_value;
         MODE_WRITE:  return beat.write_value;
         MODE_LSHIFT: begin
            shifted = ccs << 12;
            return (ccs & KeepTopMask) | (shifted >> 2);
         end
         MODE_RSHIFT: return (ccs & KeepTopMask) | (ccs >> 10);
         default:     return ccs;
      endcase
   endfunction

   always @(posedge clock) begin
      logic [31:0] expected;
      if (reset) begin
         ccs_model = '0;
         expected_ccs.delete();
      end else begin
         // pop before push so a stray response cannot match a beat taken this cycle
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_ccs.size() == 0) begin
               $error("ccs_out: response beat with nothing expected, actual %h",
                      rsp_mon.data.ccs_out);
               failures++;
            end else begin
               expected = expected_ccs.pop_front();
               if (rsp_mon.data.ccs_out !== expected) begin
                  $error("ccs_out mismatch: expected %h, actual %h",
                         expected, rsp_mon.data.ccs_out);
                  failures++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            ccs_model = next_ccs(ccs_model, req_mon.data);
            expected_ccs.push_back(ccs_model);
         end
      end
      fail_count    <= failures;
      pending_beats <= expected_ccs.size();
   end

endmodule

FILE: tb/sv/condition_flag_evaluator_tb.sv
// Testbench top for the condition flag evaluator: clock, reset, request and
// response traffic with random gaps, and the verdict.
// Depends on cfe_pkg, cfe_if.sv, the block and ccs_update_checker.
`timescale 1ns / 1ps

module condition_flag_evaluator_tb;
   import cfe_pkg::*;

   localparam int         CycleLimit         = 400000;
   localparam int         DrainCycles        = 10;
   localparam int         RandomBeats        = 1450;
   localparam logic [3:0] ModeUndefinedFirst = 4'd13;
   localparam logic [3:0] ModeUndefinedLast  = 4'd15;

   logic clock = 1'b0;
   logic reset;
   bit   calm;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_beats;

   cfe_req_if req_bus ();
   cfe_rsp_if rsp_bus ();

   condition_flag_evaluator DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   ccs_update_checker ccs_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_beats (pending_beats)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'($urandom_range(0, 255));
         5: return $urandom & 32'hFFFF_FF00;
         6: return $urandom & 32'hFFFF_0000;
         7: return $urandom & 32'h0001_80FF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type evaluation_beat(input mode_type mode,
                                                       input logic [31:0] src, dst, res,
                                                       input logic [2:0] size,
                                                       input logic sub, addc);
      req_payload_type beat;
      beat = '0;
      beat.mode              = mode;
      beat.src_value         = src;
      beat.dst_value         = dst;
      beat.result_value      = res;
      beat.operand_size      = size;
      beat.is_sub_or_cmp     = sub;
      beat.is_add_with_carry = addc;
      beat.flag_mask         = '1;
      return beat;
   endfunction

   function automatic req_payload_type register_beat(input logic [3:0] mode,
                                                     input logic [31:0] value);
      req_payload_type beat;
      beat = '0;
      beat.mode        = mode;
      beat.write_value = value;
      beat.flag_mask   = '1;
      return beat;
   endfunction

   function automatic req_payload_type random_beat();
      req_payload_type beat;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 72) beat.mode = 4'($urandom_range(MODE_GENERAL, MODE_MOVE2));
      else if (pick < 95) beat.mode = 4'($urandom_range(MODE_SETF, MODE_RSHIFT));
      else beat.mode = 4'($urandom_range(ModeUndefinedFirst, ModeUndefinedLast));
      beat.src_value     = random_operand();
      beat.dst_value     = random_operand();
      beat.result_value  = random_operand();
      beat.is_sub_or_cmp = 1'($urandom_range(0, 1));
      // make the result a real sum or difference now and then
      if ($urandom_range(0, 2) == 0)
         beat.result_value = beat.is_sub_or_cmp ? beat.dst_value - beat.src_value
                                                : beat.dst_value + beat.src_value;
      case ($urandom_range(0, 7))
         0:       beat.operand_size = 3'($urandom_range(0, 7));
         1, 2:    beat.operand_size = 3'd1;
         3, 4:    beat.operand_size = 3'd2;
         default: beat.operand_size = 3'd4;
      endcase
      beat.is_add_with_carry = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
         0:       beat.flag_mask = $urandom;
         1:       beat.flag_mask = 32'($urandom_range(0, 511));
         default: beat.flag_mask = '1;
      endcase
      beat.x_override_valid = 1'($urandom_range(0, 1));
      beat.x_override_value = 1'($urandom_range(0, 1));
      beat.write_value = ($urandom_range(0, 3) == 0) ? (32'd1 << FlagXBit) : random_operand();
      return beat;
   endfunction

   task automatic send_beat(input req_payload_type beat);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= beat;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // response side: random stalls, none while calm
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      req_payload_type beat;
      calm = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_beat(register_beat(MODE_READ, '0));
      send_beat(register_beat(MODE_WRITE, 32'hFFFF_FFFF));
      send_beat(register_beat(MODE_LSHIFT, '0));
      send_beat(register_beat(MODE_RSHIFT, '0));
      send_beat(register_beat(MODE_CLRF, 32'hFFFF_FFFF));
      send_beat(register_beat(MODE_SETF, 32'd1 << FlagXBit));
      // stored X holds Z, then X is gone for the next one
      send_beat(evaluation_beat(MODE_GENERAL, 32'h0, 32'h0, 32'h0, 3'd4, 1'b0, 1'b0));
      send_beat(evaluation_beat(MODE_GENERAL, 32'h80, 32'h80, 32'h100, 3'd1, 1'b0, 1'b0));
      send_beat(evaluation_beat(MODE_GENERAL, 32'h8000, 32'h0, 32'h8000, 3'd2, 1'b1, 1'b0));
      send_beat(evaluation_beat(MODE_GENERAL, 32'h8000_0000, 32'h1, 32'h0, 3'd3, 1'b1, 1'b0));
      send_beat(evaluation_beat(MODE_GENERAL, 32'h0, 32'h0, 32'h8000_0000, 3'd4, 1'b0, 1'b1));
      send_beat(evaluation_beat(MODE_ALU4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                                3'd4, 1'b1, 1'b0));
      send_beat(evaluation_beat(MODE_MCP, 32'h8000_0000, 32'h0, 32'h0, 3'd4, 1'b0, 1'b0));
      send_beat(evaluation_beat(MODE_MULS, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                                3'd4, 1'b0, 1'b0));
      send_beat(evaluation_beat(MODE_MULS, 32'h8000_0000, 32'h8000_0000, 32'h0,
                                3'd4, 1'b0, 1'b0));
      send_beat(evaluation_beat(MODE_MULS, 32'h0, 32'h1234_5678, 32'h0, 3'd4, 1'b0, 1'b0));
      send_beat(evaluation_beat(MODE_MULU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1,
                                3'd4, 1'b0, 1'b0));
      send_beat(evaluation_beat(MODE_MULU, 32'h0, 32'hFFFF_FFFF, 32'h0, 3'd4, 1'b0, 1'b0));
      send_beat(evaluation_beat(MODE_MOVE4, 32'h0, 32'h0, 32'h8000_0000, 3'd4, 1'b0, 1'b0));
      send_beat(evaluation_beat(MODE_MOVE4, 32'h0, 32'h0, 32'h0, 3'd4, 1'b0, 1'b1));
      send_beat(evaluation_beat(MODE_MOVE2, 32'h0, 32'h0, 32'h0000_8000, 3'd2, 1'b0, 1'b0));
      beat = evaluation_beat(MODE_MOVE2, 32'h0, 32'h0, 32'hFFFF_0000, 3'd2, 1'b0, 1'b0);
      beat.x_override_valid = 1'b1;
      beat.x_override_value = 1'b1;
      send_beat(beat);
      beat = evaluation_beat(MODE_GENERAL, 32'h0, 32'h0, 32'h0, 3'd4, 1'b0, 1'b0);
      beat.flag_mask        = 32'h0000_0003;
      beat.x_override_valid = 1'b1;
      send_beat(beat);
      send_beat(register_beat(ModeUndefinedLast, 32'h1234_5678));
      send_beat(register_beat(MODE_WRITE, 32'hC00F_FFFF));
      send_beat(register_beat(MODE_LSHIFT, '0));
      send_beat(register_beat(MODE_RSHIFT, '0));

      for (int i = 0; i < RandomBeats; i++) begin
         if (i % 150 == 0) calm = ($urandom_range(0, 2) == 0);
         send_beat(random_beat());
      end
      calm = 1'b0;
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (pending_beats != 0) $error("ccs_out: %0d expected beats never arrived", pending_beats);
      if (fail_count == 0 && pending_beats == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/cfe_pkg.sv
src/cfe_if.sv
src/condition_flag_evaluator.sv
tb/sv/ccs_update_checker.sv
tb/sv/condition_flag_evaluator_tb.sv
